// ===== hdl/psn_rot_pkg.sv =====
// ----------------------------------------------------------------------------
// psn receive order tracker package
// shared widths, verdict codes and serial-number compare
// ----------------------------------------------------------------------------
package psn_rot_pkg;

   localparam int SEQ_W    = 32;
   localparam int WINDOW_W = 17;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(64);
   localparam logic [SEQ_W-1:0]    SEQ_HALF     = 32'h8000_0000;

   typedef logic [SEQ_W-1:0]    seq_type;
   typedef logic [WINDOW_W-1:0] window_type;

   typedef enum logic [2:0] {
      VERDICT_ACK_ONLY   = 3'd0,
      VERDICT_IN_ORDER   = 3'd1,
      VERDICT_NEW_GAP    = 3'd2,
      VERDICT_EXTENDED   = 3'd3,
      VERDICT_DUPLICATE  = 3'd4,
      VERDICT_OUT_RANGE  = 3'd5,
      VERDICT_RETRANSMIT = 3'd6
   } verdict_type;

   // a before b when b - a lies in 1 .. 2^31 - 1
   function automatic logic seq_before(input seq_type a, input seq_type b);
      seq_type d;
      d = b - a;
      return (d != '0) && (d < SEQ_HALF);
   endfunction

endpackage

// ===== hdl/psn_rot_ifs.sv =====
// ----------------------------------------------------------------------------
// psn receive order tracker channels
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface psn_rot_req_if;
   import psn_rot_pkg::*;

   logic    valid;
   logic    ready;
   seq_type packet_seq;
   seq_type peer_ack_seq;
   logic    has_payload;

   modport source (output valid, output packet_seq, output peer_ack_seq,
                   output has_payload, input ready);
   modport sink   (input valid, input packet_seq, input peer_ack_seq,
                   input has_payload, output ready);
endinterface

interface psn_rot_rsp_if;
   import psn_rot_pkg::*;

   logic        valid;
   logic        ready;
   verdict_type verdict;
   logic        deliver;
   logic        ack_due;
   logic        gap_open;
   seq_type     expected_seq;
   seq_type     gap_low;
   seq_type     gap_high;
   seq_type     acked_seq;
   seq_type     send_limit_seq;

   modport source (output valid, output verdict, output deliver, output ack_due,
                   output gap_open, output expected_seq, output gap_low,
                   output gap_high, output acked_seq, output send_limit_seq,
                   input ready);
   modport sink   (input valid, input verdict, input deliver, input ack_due,
                   input gap_open, input expected_seq, input gap_low,
                   input gap_high, input acked_seq, input send_limit_seq,
                   output ready);
endinterface

interface psn_rot_csr_if;
   import psn_rot_pkg::*;

   logic       valid;
   logic       ready;
   window_type send_window;

   modport source (output valid, output send_window, input ready);
   modport sink   (input valid, input send_window, output ready);
endinterface

// ===== hdl/psn_receive_order_tracker.sv =====
// ----------------------------------------------------------------------------
// psn receive order tracker
// tracks received sequence numbers with one out-of-order range
//
// req_chan takes one received transport header per request: packet sequence,
// peer cumulative acknowledgement and a payload flag. rsp_chan returns one
// response per request with the verdict, deliver and ack-due flags, the
// expected sequence, the tracked range, the recorded peer acknowledgement
// and the send limit (peer ack + send window - 1).
// csr_chan writes the send window; it is always ready. It is to be written only
// while no request is in flight; the block itself does not enforce this.
// A request is registered on acceptance and evaluated against the tracker
// state when the response register can take it (empty, or its response taken
// in that cycle); the response register is then loaded and rsp_chan.valid
// rises. Throughput one request per cycle while rsp_chan does not stall, set
// by the state update loop.
// Reset clears the tracker state, empties both registers and sets the send
// window to 64. When rsp_chan stalls the response holds, the input register
// fills, and req_chan.ready drops until the response is taken.
// ----------------------------------------------------------------------------
module psn_receive_order_tracker (
   input  logic clock,
   input  logic reset,
   psn_rot_csr_if.sink   csr_chan,
   psn_rot_req_if.sink   req_chan,
   psn_rot_rsp_if.source rsp_chan
);
   import psn_rot_pkg::*;

   // request register
   logic    req_valid_ff;
   seq_type req_seq_ff;
   seq_type req_ack_ff;
   logic    req_payload_ff;

   // tracker state
   seq_type    next_exp_ff,  next_exp_in;
   seq_type    range_low_ff, range_low_in;
   seq_type    range_high_ff, range_high_in;
   logic       range_valid_ff, range_valid_in;
   seq_type    peer_acked_ff;
   window_type window_ff;

   // response register
   logic        rsp_valid_ff;
   verdict_type verdict_ff, verdict_in;
   logic        deliver_ff, deliver_in;
   logic        ack_due_ff, ack_due_in;
   logic        gap_open_ff;
   seq_type     expected_ff;
   seq_type     gap_low_ff;
   seq_type     gap_high_ff;
   seq_type     acked_ff;
   seq_type     limit_ff, limit_in;

   logic    advance;
   logic    req_take;
   seq_type exp_inc;
   seq_type seq_inc;

   assign advance  = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign exp_inc = next_exp_ff + 1'b1;
   assign seq_inc = req_seq_ff + 1'b1;
   assign limit_in = req_ack_ff + {{(SEQ_W-WINDOW_W){1'b0}}, window_ff} - 1'b1;

   always_comb begin
      next_exp_in    = next_exp_ff;
      range_low_in   = range_low_ff;
      range_high_in  = range_high_ff;
      range_valid_in = range_valid_ff;
      verdict_in     = VERDICT_ACK_ONLY;
      deliver_in     = 1'b0;
      ack_due_in     = 1'b0;
      if (req_payload_ff) begin
         if (req_seq_ff == next_exp_ff) begin
            next_exp_in = exp_inc;
            if (range_valid_ff && (exp_inc == range_low_ff)) begin
               next_exp_in    = range_high_ff;
               range_valid_in = 1'b0;
            end
            verdict_in = VERDICT_IN_ORDER;
            deliver_in = 1'b1;
            ack_due_in = 1'b1;
         end else if (seq_before(next_exp_ff, req_seq_ff)) begin
            if (range_valid_ff) begin
               if (req_seq_ff == range_high_ff) begin
                  range_high_in = seq_inc;
                  verdict_in    = VERDICT_EXTENDED;
                  deliver_in    = 1'b1;
                  ack_due_in    = 1'b1;
               end else if (seq_inc == range_low_ff) begin
                  range_low_in = req_seq_ff;
                  if (req_seq_ff == next_exp_ff) begin
                     next_exp_in    = range_high_ff;
                     range_valid_in = 1'b0;
                  end
                  verdict_in = VERDICT_EXTENDED;
                  deliver_in = 1'b1;
                  ack_due_in = 1'b1;
               end else if (seq_before(req_seq_ff, range_low_ff) ||
                            seq_before(range_high_ff, req_seq_ff)) begin
                  verdict_in = VERDICT_OUT_RANGE;
               end else begin
                  verdict_in = VERDICT_DUPLICATE;
               end
            end else begin
               range_valid_in = 1'b1;
               range_low_in   = req_seq_ff;
               range_high_in  = seq_inc;
               verdict_in     = VERDICT_NEW_GAP;
               deliver_in     = 1'b1;
               ack_due_in     = 1'b1;
            end
         end else begin
            verdict_in = VERDICT_RETRANSMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         next_exp_ff    <= '0;
         range_low_ff   <= '0;
         range_high_ff  <= '0;
         range_valid_ff <= 1'b0;
         peer_acked_ff  <= '0;
         window_ff      <= WINDOW_RESET;
      end else begin
         if (csr_chan.valid) begin
            window_ff <= csr_chan.send_window;
         end
         if (req_chan.ready) begin
            req_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            next_exp_ff    <= next_exp_in;
            range_low_ff   <= range_low_in;
            range_high_ff  <= range_high_in;
            range_valid_ff <= range_valid_in;
            peer_acked_ff  <= req_ack_ff;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_seq_ff     <= req_chan.packet_seq;
         req_ack_ff     <= req_chan.peer_ack_seq;
         req_payload_ff <= req_chan.has_payload;
      end
      if (advance) begin
         verdict_ff  <= verdict_in;
         deliver_ff  <= deliver_in;
         ack_due_ff  <= ack_due_in;
         gap_open_ff <= range_valid_in;
         expected_ff <= next_exp_in;
         gap_low_ff  <= range_valid_in ? range_low_in : '0;
         gap_high_ff <= range_valid_in ? range_high_in : '0;
         acked_ff    <= req_ack_ff;
         limit_ff    <= limit_in;
      end
   end

   // peer_acked_ff mirrors the last recorded acknowledgement
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.verdict        = verdict_ff;
   assign rsp_chan.deliver        = deliver_ff;
   assign rsp_chan.ack_due        = ack_due_ff;
   assign rsp_chan.gap_open       = gap_open_ff;
   assign rsp_chan.expected_seq   = expected_ff;
   assign rsp_chan.gap_low        = gap_low_ff;
   assign rsp_chan.gap_high       = gap_high_ff;
   assign rsp_chan.acked_seq      = rsp_valid_ff ? acked_ff : peer_acked_ff;
   assign rsp_chan.send_limit_seq = limit_ff;

endmodule
